@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/ffba_pkg.sv @@
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int HEADER_BYTES = 32;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 27;
  localparam int ECNT_W  = 16;
  localparam int PROD_W  = SIZE_W + ECNT_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 152;
  localparam int CFG_IDX_W  = 1;

  // request kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_ZALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;
  localparam logic [1:0] KIND_RESIZE = 2'd3;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

@@ hdl/ffba_table.sv @@
// Block table storage: one write port, one registered read port.
module ffba_table
  import ffba_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator: sequencer, counters and ports.
//
// Usage: requests enter as words on the in_ channel (tuser = kind, tdata =
// size, element count, block address). Each request gives exactly one word
// on the out_ channel with the returned address (tdata), the status (tuser)
// and all statistics counters as they stand after the request.
// Configuration (heap limit, largest request) goes over the cfg_ channel,
// always ready; the user must write it only while no request is in flight
// (the block does not enforce this). One request is worked on at a time;
// in_tready is low while it runs. After accept, a request passes the
// multiply step and the check step; a bad size or a free of null then goes
// straight to the result word, else the table scan, an append and the
// freeing of an old block follow as needed. The table is read one entry
// per cycle through a registered read port; a first-fit scan and an
// address lookup each visit up to block_count entries.
// The finished word sits in an output register: the next request may be
// accepted while it waits, and the sequencer stalls only when it has a
// new word and the previous one is still not taken.
// Reset (synchronous, rst_n low) empties the heap and clears counters;
// table contents need no clearing since only entries below block_count
// are ever read.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: request_size[26:0], element_count[42:27], block_addr[74:43]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: result_addr[31:0], free_block_count[40:32],
  // free_byte_count[72:41], block_count[81:73], block_byte_count[113:82],
  // header_byte_count[145:114]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_FIND     = 4'd3;
  localparam logic [3:0] S_FIT      = 4'd4;
  localparam logic [3:0] S_APPEND   = 4'd5;
  localparam logic [3:0] S_FREE_OLD = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // latched request
  logic [1:0]        kind_r, kind_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PROD_W-1:0] size_r, size_nxt;

  // block found by address lookup
  logic [IDX_W-1:0]  old_idx_r, old_idx_nxt;
  logic [ADDR_W-1:0] old_start_r, old_start_nxt;
  logic [SIZE_W-1:0] old_size_r, old_size_nxt;
  logic              old_free_r, old_free_nxt;

  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [1:0]        res_status_r, res_status_nxt;

  // heap state and statistics
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [ADDR_W-1:0] heap_top_r, heap_top_nxt;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [ADDR_W-1:0] free_sum_r, free_sum_nxt;
  logic [ADDR_W-1:0] bytes_r, bytes_nxt;
  logic [ADDR_W-1:0] hdr_bytes_r, hdr_bytes_nxt;

  logic [ADDR_W-1:0] heap_limit_r;
  logic [SIZE_W-1:0] max_req_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_load;

  tbl_wr_t tbl_wr;
  entry_t  rd_data;

  logic              in_acc;
  logic              last_entry;
  logic              size_ok;
  logic [SIZE_W-1:0] alloc_size;
  logic              addr_hit;
  logic              fit_hit;
  logic              move_old;
  logic [ADDR_W+1:0] heap_end;
  logic              table_full;

  ffba_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (idx_nxt),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // rd_data always holds entry idx_r: the read address is idx_nxt
  assign last_entry = ({1'b0, idx_r} + CNT_W'(1)) == used_r;
  assign size_ok    = (size_r != '0) && (size_r <= PROD_W'(max_req_r));
  assign alloc_size = size_r[SIZE_W-1:0];
  assign addr_hit   = ({1'b0, rd_data.start} + (ADDR_W+1)'(HEADER_BYTES))
                      == {1'b0, addr_r};
  assign fit_hit    = rd_data.free && (rd_data.size >= alloc_size);
  assign move_old   = (kind_r == KIND_RESIZE) && (addr_r != '0);
  assign heap_end   = {2'b00, heap_top_r} + (ADDR_W+2)'(HEADER_BYTES)
                      + (ADDR_W+2)'(alloc_size);
  assign table_full = used_r >= CNT_W'(MAX_BLOCKS);

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    kind_nxt        = kind_r;
    req_nxt         = req_r;
    ecnt_nxt        = ecnt_r;
    addr_nxt        = addr_r;
    size_nxt        = size_r;
    old_idx_nxt     = old_idx_r;
    old_start_nxt   = old_start_r;
    old_size_nxt    = old_size_r;
    old_free_nxt    = old_free_r;
    res_addr_nxt    = res_addr_r;
    res_status_nxt  = res_status_r;
    used_nxt        = used_r;
    heap_top_nxt    = heap_top_r;
    free_cnt_nxt    = free_cnt_r;
    free_sum_nxt    = free_sum_r;
    bytes_nxt       = bytes_r;
    hdr_bytes_nxt   = hdr_bytes_r;
    out_valid_nxt   = out_valid_r;
    out_load        = 1'b0;
    tbl_wr          = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          kind_nxt       = in_tuser;
          req_nxt        = in_tdata[SIZE_W-1:0];
          ecnt_nxt       = in_tdata[SIZE_W+ECNT_W-1:SIZE_W];
          addr_nxt       = in_tdata[SIZE_W+ECNT_W+ADDR_W-1:SIZE_W+ECNT_W];
          res_addr_nxt   = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_MUL;
        end
      end

      S_MUL: begin
        if (kind_r == KIND_ZALLOC) begin
          size_nxt = PROD_W'(req_r) * PROD_W'(ecnt_r);
        end else begin
          size_nxt = PROD_W'(req_r);
        end
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (kind_r == KIND_FREE) begin
          if (addr_r == '0) begin
            state_nxt = S_DONE;
          end else if (used_r == '0) begin
            res_status_nxt = ST_UNKNOWN;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end else if (!size_ok) begin
          res_status_nxt = ST_BAD_SIZE;
          state_nxt      = S_DONE;
        end else if (move_old) begin
          if (used_r == '0) begin
            res_status_nxt = ST_UNKNOWN;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end else if (used_r == '0) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_FIT;
        end
      end

      S_FIND: begin
        if (addr_hit) begin
          old_idx_nxt   = idx_r;
          old_start_nxt = rd_data.start;
          old_size_nxt  = rd_data.size;
          old_free_nxt  = rd_data.free;
          if (kind_r == KIND_FREE) begin
            state_nxt = S_FREE_OLD;
          end else if (rd_data.size >= alloc_size) begin
            res_addr_nxt = addr_r;
            state_nxt    = S_DONE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FIT;
          end
        end else if (last_entry) begin
          res_status_nxt = ST_UNKNOWN;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_FIT: begin
        if (fit_hit) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = idx_r;
          tbl_wr.data.start = rd_data.start;
          tbl_wr.data.size  = rd_data.size;
          tbl_wr.data.free  = 1'b0;
          free_cnt_nxt      = free_cnt_r - CNT_W'(1);
          free_sum_nxt      = free_sum_r - ADDR_W'(rd_data.size);
          res_addr_nxt      = rd_data.start + ADDR_W'(HEADER_BYTES);
          state_nxt         = move_old ? S_FREE_OLD : S_DONE;
        end else if (last_entry) begin
          state_nxt = S_APPEND;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_APPEND: begin
        if (table_full || (heap_end > (ADDR_W+2)'(heap_limit_r))) begin
          // failed resize keeps the old block
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_DONE;
        end else begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = used_r[IDX_W-1:0];
          tbl_wr.data.start = heap_top_r;
          tbl_wr.data.size  = alloc_size;
          tbl_wr.data.free  = 1'b0;
          used_nxt          = used_r + CNT_W'(1);
          heap_top_nxt      = heap_end[ADDR_W-1:0];
          bytes_nxt         = bytes_r + ADDR_W'(alloc_size);
          hdr_bytes_nxt     = hdr_bytes_r + ADDR_W'(HEADER_BYTES);
          res_addr_nxt      = heap_top_r + ADDR_W'(HEADER_BYTES);
          state_nxt         = move_old ? S_FREE_OLD : S_DONE;
        end
      end

      S_FREE_OLD: begin
        // freeing a block that is already free changes nothing
        if (!old_free_r) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.addr       = old_idx_r;
          tbl_wr.data.start = old_start_r;
          tbl_wr.data.size  = old_size_r;
          tbl_wr.data.free  = 1'b1;
          free_cnt_nxt      = free_cnt_r + CNT_W'(1);
          free_sum_nxt      = free_sum_r + ADDR_W'(old_size_r);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      idx_r         <= '0;
      used_r        <= '0;
      heap_top_r    <= '0;
      free_cnt_r    <= '0;
      free_sum_r    <= '0;
      bytes_r       <= '0;
      hdr_bytes_r   <= '0;
      heap_limit_r  <= ADDR_W'(1048576);
      max_req_r     <= SIZE_W'(100000000);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      used_r        <= used_nxt;
      heap_top_r    <= heap_top_nxt;
      free_cnt_r    <= free_cnt_nxt;
      free_sum_r    <= free_sum_nxt;
      bytes_r       <= bytes_nxt;
      hdr_bytes_r   <= hdr_bytes_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HEAP_LIMIT:  heap_limit_r <= cfg_data;
          REG_MAX_REQUEST: max_req_r    <= cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    ecnt_r       <= ecnt_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    old_idx_r    <= old_idx_nxt;
    old_start_r  <= old_start_nxt;
    old_size_r   <= old_size_nxt;
    old_free_r   <= old_free_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_data_r <= {6'b0, hdr_bytes_r, bytes_r, used_r, free_sum_r,
                     free_cnt_r, res_addr_r};
      out_user_r <= res_status_r;
    end
  end

  // free blocks never outnumber created blocks
  `AST_IMP(a_free_le_used, 1'b1, free_cnt_r <= used_r)
  // table never grows past its depth
  `AST_IMP(a_used_bound, 1'b1, used_r <= CNT_W'(MAX_BLOCKS))
  // table is written only by the allocate and free steps
  `AST_IMP(a_wr_state, tbl_wr.en,
           (state_r == S_FIT) || (state_r == S_APPEND) || (state_r == S_FREE_OLD))
  // a result word is launched only from the finishing step
  `AST_NXT(a_out_from_done, !out_valid_r, !out_valid_r || ($past(state_r) == S_DONE))

endmodule
